>>> src/tcas_pkg.sv
// ----------------------------------------------------------------------------
// tcas_pkg
// shared types and constants of the text cell to ansi stream encoder
// ----------------------------------------------------------------------------
package tcas_pkg;

    localparam int unsigned NUM_POS = 19;

    localparam logic [1:0] CFG_ANSI    = 2'd0;
    localparam logic [1:0] CFG_NEWLINE = 2'd1;
    localparam logic [1:0] CFG_QUOTE   = 2'd2;

    localparam logic [7:0] BYTE_ESC   = 8'h1b;
    localparam logic [7:0] BYTE_LBR   = 8'h5b;
    localparam logic [7:0] BYTE_SEMI  = 8'h3b;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_ONE   = 8'h31;
    localparam logic [7:0] BYTE_THREE = 8'h33;
    localparam logic [7:0] BYTE_FOUR  = 8'h34;
    localparam logic [7:0] BYTE_FIVE  = 8'h35;
    localparam logic [7:0] BYTE_M     = 8'h6d;
    localparam logic [7:0] BYTE_BSL   = 8'h5c;
    localparam logic [7:0] BYTE_TICK  = 8'h60;
    localparam logic [7:0] BYTE_DOLL  = 8'h24;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_LF    = 8'h0a;

    // byte positions of one cell's run
    localparam int unsigned POS_ESC    = 0;
    localparam int unsigned POS_LBR    = 1;
    localparam int unsigned POS_BOLD   = 2;
    localparam int unsigned POS_SEMI0  = 3;
    localparam int unsigned POS_BLINK  = 4;
    localparam int unsigned POS_SEMI1  = 5;
    localparam int unsigned POS_THREE  = 6;
    localparam int unsigned POS_FG     = 7;
    localparam int unsigned POS_SEMI2  = 8;
    localparam int unsigned POS_FOUR   = 9;
    localparam int unsigned POS_BG     = 10;
    localparam int unsigned POS_M      = 11;
    localparam int unsigned POS_QUOTE  = 12;
    localparam int unsigned POS_CHAR   = 13;
    localparam int unsigned POS_LF     = 14;
    localparam int unsigned POS_RESC   = 15;
    localparam int unsigned POS_RLBR   = 16;
    localparam int unsigned POS_RZERO  = 17;
    localparam int unsigned POS_RM     = 18;

    typedef struct packed {
        logic [NUM_POS-1:0] mask;
        logic [7:0]         ch;
        logic               bold;
        logic [2:0]         fg3;
        logic [2:0]         bg3;
    } cmd_t;

    function automatic logic [7:0] pos_byte(input int unsigned pos, input cmd_t c);
        logic [7:0] b;
        case (pos)
            POS_ESC:   b = BYTE_ESC;
            POS_LBR:   b = BYTE_LBR;
            POS_BOLD:  b = c.bold ? BYTE_ONE : BYTE_ZERO;
            POS_SEMI0: b = BYTE_SEMI;
            POS_BLINK: b = BYTE_FIVE;
            POS_SEMI1: b = BYTE_SEMI;
            POS_THREE: b = BYTE_THREE;
            POS_FG:    b = BYTE_ZERO | {5'd0, c.fg3};
            POS_SEMI2: b = BYTE_SEMI;
            POS_FOUR:  b = BYTE_FOUR;
            POS_BG:    b = BYTE_ZERO | {5'd0, c.bg3};
            POS_M:     b = BYTE_M;
            POS_QUOTE: b = BYTE_BSL;
            POS_CHAR:  b = c.ch;
            POS_LF:    b = BYTE_LF;
            POS_RESC:  b = BYTE_ESC;
            POS_RLBR:  b = BYTE_LBR;
            POS_RZERO: b = BYTE_ZERO;
            POS_RM:    b = BYTE_M;
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> src/tcas_front.sv
// ----------------------------------------------------------------------------
// tcas_front
// accepts cells, holds configuration and colour state, builds byte run masks
// ----------------------------------------------------------------------------
module tcas_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [0:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_char_code,
    input  logic [7:0]          s_attribute,
    input  logic                s_row_end,
    input  logic                s_frame_end,
    input  logic                q_full,
    output logic                q_push,
    output tcas_pkg::cmd_t      q_cmd
);

    logic       ansi_reg, newline_reg, quote_reg;
    logic       known_reg, known_next;
    logic [3:0] fore_reg, fore_next;
    logic [3:0] back_reg, back_next;
    logic       need_esc, need_quote, blink;
    logic [7:0] ch;
    logic [tcas_pkg::NUM_POS-1:0] mask;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign blink   = s_attribute[3];

    always_comb begin
        need_esc = ansi_reg && (!known_reg || s_attribute[7:4] != fore_reg
                                || s_attribute[3:0] != back_reg);
        ch = (s_char_code <= 8'd32) ? tcas_pkg::BYTE_SPACE : s_char_code;
        need_quote = quote_reg && (ch == tcas_pkg::BYTE_BSL || ch == tcas_pkg::BYTE_TICK
                                   || ch == tcas_pkg::BYTE_DOLL);
        mask = '0;
        mask[tcas_pkg::POS_ESC]   = need_esc;
        mask[tcas_pkg::POS_LBR]   = need_esc;
        mask[tcas_pkg::POS_BOLD]  = need_esc;
        mask[tcas_pkg::POS_SEMI0] = need_esc;
        mask[tcas_pkg::POS_BLINK] = need_esc && blink;
        mask[tcas_pkg::POS_SEMI1] = need_esc && blink;
        mask[tcas_pkg::POS_THREE] = need_esc;
        mask[tcas_pkg::POS_FG]    = need_esc;
        mask[tcas_pkg::POS_SEMI2] = need_esc;
        mask[tcas_pkg::POS_FOUR]  = need_esc;
        mask[tcas_pkg::POS_BG]    = need_esc;
        mask[tcas_pkg::POS_M]     = need_esc;
        mask[tcas_pkg::POS_QUOTE] = need_quote;
        mask[tcas_pkg::POS_CHAR]  = 1'b1;
        mask[tcas_pkg::POS_LF]    = s_row_end && newline_reg;
        mask[tcas_pkg::POS_RESC]  = s_frame_end && ansi_reg;
        mask[tcas_pkg::POS_RLBR]  = s_frame_end && ansi_reg;
        mask[tcas_pkg::POS_RZERO] = s_frame_end && ansi_reg;
        mask[tcas_pkg::POS_RM]    = s_frame_end && ansi_reg;

        q_cmd.mask = mask;
        q_cmd.ch   = ch;
        q_cmd.bold = s_attribute[7];
        q_cmd.fg3  = s_attribute[6:4];
        q_cmd.bg3  = s_attribute[2:0];

        known_next = known_reg;
        fore_next  = fore_reg;
        back_next  = back_reg;
        if (q_push) begin
            if (need_esc) begin
                known_next = 1'b1;
                fore_next  = s_attribute[7:4];
                back_next  = s_attribute[3:0];
            end
            if (s_frame_end) begin
                known_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ansi_reg    <= 1'b1;
            newline_reg <= 1'b1;
            quote_reg   <= 1'b0;
            known_reg   <= 1'b0;
            fore_reg    <= 4'd0;
            back_reg    <= 4'd0;
        end else begin
            known_reg <= known_next;
            fore_reg  <= fore_next;
            back_reg  <= back_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    tcas_pkg::CFG_ANSI:    ansi_reg    <= cfg_wdata[0];
                    tcas_pkg::CFG_NEWLINE: newline_reg <= cfg_wdata[0];
                    tcas_pkg::CFG_QUOTE:   quote_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> src/tcas_queue.sv
// ----------------------------------------------------------------------------
// tcas_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module tcas_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tcas_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output tcas_pkg::cmd_t head_cmd
);

    tcas_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

>>> src/tcas_back.sv
// ----------------------------------------------------------------------------
// tcas_back
// walks the byte mask of each command and emits one byte a cycle unless m_ready stalls
// ----------------------------------------------------------------------------
module tcas_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_not_empty,
    input  tcas_pkg::cmd_t q_head,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_run_last
);

    tcas_pkg::cmd_t cur_reg;
    logic [tcas_pkg::NUM_POS-1:0] mask_reg, mask_next;
    logic [tcas_pkg::NUM_POS-1:0] lowest, rest;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_sel;
    logic       last_reg;
    logic       advance;

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_run_last = last_reg;

    always_comb begin
        lowest = mask_reg & (~mask_reg + {{(tcas_pkg::NUM_POS-1){1'b0}}, 1'b1});
        rest   = mask_reg & ~lowest;
        byte_sel = 8'h00;
        for (int unsigned i = 0; i < tcas_pkg::NUM_POS; i++) begin
            if (lowest[i]) begin
                byte_sel = byte_sel | tcas_pkg::pos_byte(i, cur_reg);
            end
        end
        advance    = (mask_reg != '0) && (!valid_reg || m_ready);
        valid_next = advance ? 1'b1 : (valid_reg && !m_ready);
        mask_next  = advance ? rest : mask_reg;
        q_pop      = (mask_next == '0) && q_not_empty;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            byte_reg <= byte_sel;
            last_reg <= (rest == '0);
        end
        if (q_pop) begin
            cur_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            mask_reg  <= q_pop ? q_head.mask : mask_next;
        end
    end

endmodule

>>> src/text_cell_to_ansi_stream_top.sv
// ----------------------------------------------------------------------------
// text_cell_to_ansi_stream_top
// text cells in, ansi colour byte stream out
// a cell goes from the queue to the back end's mask register, and its bytes to
// the output byte register; throughput: one byte per cycle unless m_ready
// stalls; a cell makes 1 to 19 bytes, sent as the back end walks the byte mask
// a two-entry queue lets cells be accepted while earlier runs are emitted
// reset: synchronous active-low aresetn resets queue, colour state and config
// ----------------------------------------------------------------------------
module text_cell_to_ansi_stream_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [0:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic [7:0] s_attribute,
    input  logic       s_row_end,
    input  logic       s_frame_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    tcas_pkg::cmd_t push_cmd, head_cmd;
    logic push, pop, full, not_empty;

    tcas_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_attribute (s_attribute),
        .s_row_end   (s_row_end),
        .s_frame_end (s_frame_end),
        .q_full      (full),
        .q_push      (push),
        .q_cmd       (push_cmd)
    );

    tcas_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    tcas_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (not_empty),
        .q_head      (head_cmd),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last)
    );

endmodule
